@@ sv/csem_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csem_pkg
// Types and constants shared by the counting semaphore core and its cells.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int unsigned PERMIT_W  = 16;
  localparam int unsigned ID_W      = 10;
  localparam int unsigned STATUS_W  = 3;
  localparam logic [PERMIT_W-1:0] PERMIT_MAX = '1;

  typedef enum logic [0:0] {
    OP_WAIT = 1'b0,
    OP_POST = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_RELEASED = 3'd2,
    ST_ADDED    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    op_e                 op;
    logic [ID_W-1:0]     caller_id;
    logic [PERMIT_W-1:0] count;
  } in_beat_t;

  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     released_id;
    logic [PERMIT_W-1:0] permits_now;
  } out_beat_t;

  // One waiter held in a cell.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [PERMIT_W-1:0] need;
  } waiter_t;

  // Control broadcast from the core to every cell.
  typedef struct packed {
    logic    insert;
    logic    pop;
    waiter_t fresh;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ sv/counting_semaphore_wait_n_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counting_semaphore_wait_n_core
// Counting semaphore with a wait queue sorted by permits needed.
// ----------------------------------------------------------------------------
// The core takes one wait or post beat per clock and returns exactly one result
// beat for each, registered in the cycle after acceptance. The queue is a row of
// QUEUE_DEPTH cells that compare their need against a new waiter in parallel,
// so a sorted insert or a head release lands at the edge that registers the
// result; the permit add and compare sets the cycle. A result waiting in the
// output register does not stop the next beat as long as the consumer takes
// it in the same cycle. Writing the configuration register loads the permit
// count and empties the queue; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_n_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  csem_pkg::in_beat_t           in_beat_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output csem_pkg::out_beat_t          out_beat_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [csem_pkg::PERMIT_W-1:0] cfg_data_i
);
  import csem_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [PERMIT_W-1:0] permits_q, permits_d;
  logic [CNT_W-1:0]    total_q, total_d;
  logic                out_valid_q;
  out_beat_t           out_beat_q, out_beat_d;

  cell_ctrl_t          ctrl;
  waiter_t             entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gts;

  logic                accept;
  logic                granted;
  logic                has_room;
  logic [PERMIT_W-1:0] plus_one;
  logic                release_head;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign granted      = permits_q >= in_beat_i.count;
  assign has_room     = total_q < CNT_W'(QUEUE_DEPTH);
  assign plus_one     = (permits_q == PERMIT_MAX) ? PERMIT_MAX : permits_q + 1'b1;
  assign release_head = (total_q != '0) && (plus_one >= entries[0].need);

  assign ctrl.fresh.id   = in_beat_i.caller_id;
  assign ctrl.fresh.need = in_beat_i.count;
  assign ctrl.insert     = accept && (in_beat_i.op == OP_WAIT) && !granted && has_room;
  assign ctrl.pop        = accept && (in_beat_i.op == OP_POST) && release_head;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      waiter_t prev_w, next_w;
      logic    prev_gt;

      if (gi == 0) begin : g_head
        assign prev_w  = '0;
        assign prev_gt = 1'b0;
      end else begin : g_body
        assign prev_w  = entries[gi-1];
        assign prev_gt = gts[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign next_w = entries[gi];
      end else begin : g_inner
        assign next_w = entries[gi+1];
      end

      csem_cell u_cell (
        .clk_i     (clk_i),
        .ctrl_i    (ctrl),
        .occ_i     (total_q > CNT_W'(gi)),
        .at_tail_i (total_q == CNT_W'(gi)),
        .prev_i    (prev_w),
        .prev_gt_i (prev_gt),
        .next_i    (next_w),
        .entry_o   (entries[gi]),
        .gt_o      (gts[gi])
      );
    end
  endgenerate

  always_comb begin
    permits_d  = permits_q;
    total_d    = total_q;
    out_beat_d = out_beat_q;
    if (accept) begin
      out_beat_d.released_id = '0;
      if (in_beat_i.op == OP_WAIT) begin
        if (granted) begin
          permits_d         = permits_q - in_beat_i.count;
          out_beat_d.status = ST_GRANTED;
        end else if (has_room) begin
          total_d           = total_q + 1'b1;
          out_beat_d.status = ST_QUEUED;
        end else begin
          out_beat_d.status = ST_FULL;
        end
      end else begin
        if (release_head) begin
          permits_d              = plus_one - entries[0].need;
          total_d                = total_q - 1'b1;
          out_beat_d.status      = ST_RELEASED;
          out_beat_d.released_id = entries[0].id;
        end else begin
          permits_d         = plus_one;
          out_beat_d.status = ST_ADDED;
        end
      end
      out_beat_d.permits_now = permits_d;
    end
    // A configuration beat reinitializes the semaphore.
    if (cfg_valid_i) begin
      permits_d = cfg_data_i;
      total_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      permits_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      permits_q <= permits_d;
      total_q   <= total_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_beat_q <= out_beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule
`default_nettype wire

@@ sv/csem_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csem_cell
// One slot of the sorted wait queue: compares its need against a new waiter
// and shifts toward the tail on insert or toward the head on release.
// ----------------------------------------------------------------------------
module csem_cell (
  input  logic                 clk_i,
  input  csem_pkg::cell_ctrl_t ctrl_i,
  input  logic                 occ_i,
  input  logic                 at_tail_i,
  input  csem_pkg::waiter_t    prev_i,
  input  logic                 prev_gt_i,
  input  csem_pkg::waiter_t    next_i,
  output csem_pkg::waiter_t    entry_o,
  output logic                 gt_o
);
  import csem_pkg::*;

  waiter_t entry_q, entry_d;

  // Occupied slots holding a strictly larger need move aside for the newcomer,
  // which keeps equal needs in arrival order.
  assign gt_o = occ_i && (entry_q.need > ctrl_i.fresh.need);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      entry_d = next_i;
    end else if (ctrl_i.insert) begin
      if (prev_gt_i) begin
        entry_d = prev_i;
      end else if (gt_o || at_tail_i) begin
        entry_d = ctrl_i.fresh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire
